// ===== rtl/core/ising_lattice_monte_carlo_unit_macros.svh =====
// Assertion macros for the Ising lattice Monte Carlo unit.
`ifndef ISING_LATTICE_MONTE_CARLO_UNIT_MACROS_SVH
`define ISING_LATTICE_MONTE_CARLO_UNIT_MACROS_SVH
`ifndef SYNTH
// Check an implication on every clock edge outside reset.
`define ILMC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ilmc assertion failed");
// Check that a condition never holds outside reset.
`define ILMC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("ilmc forbidden condition");
`else
`define ILMC_ASSERT(lbl, prop)
`define ILMC_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== rtl/core/ilmc_pkg.sv =====
// Types and constants shared by the Ising lattice Monte Carlo unit.
package ilmc_pkg;

  localparam int CountW = 15;
  localparam int ThW    = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgW   = 32;

  localparam logic [31:0] SEED_DEFAULT = 32'd2463534242;

  // operation codes
  localparam logic [1:0] OP_MOVE  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MODE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BOND   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ALOW   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_AHIGH  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SEED   = 3'd4;

  // neighbour directions; done marks a finished stack entry
  localparam logic [2:0] DIR_UP    = 3'd0;
  localparam logic [2:0] DIR_DOWN  = 3'd1;
  localparam logic [2:0] DIR_LEFT  = 3'd2;
  localparam logic [2:0] DIR_RIGHT = 3'd3;
  localparam logic [2:0] DIR_DONE  = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SITE,
    S_W_NB,
    S_W_POP,
    S_W_CHK,
    S_M_RD,
    S_M_ACC,
    S_M_LIM,
    S_M_DEC,
    S_DONE
  } state_e;

  typedef struct packed {
    logic        step;
    logic        load;
    logic [31:0] seed;
  } rng_ctrl_t;

endpackage

// ===== rtl/core/ilmc_rng.sv =====
// Xorshift32 generator that yields one 16-bit draw per step.
module ilmc_rng
  import ilmc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rng_ctrl_t     ctrl_i,
  output logic [ThW-1:0] draw_o
);

  logic [31:0] x_q, x_d, s1, s2;

  // next generator value
  always_comb begin
    s1   = x_q ^ (x_q << 13);
    s2   = s1 ^ (s1 >> 17);
    x_d  = s2 ^ (s2 << 5);
  end

  assign draw_o = x_d[31:16];

  // load seed or advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= SEED_DEFAULT;
    end else if (ctrl_i.load) begin
      x_q <= (ctrl_i.seed == 32'd0) ? SEED_DEFAULT : ctrl_i.seed;
    end else if (ctrl_i.step) begin
      x_q <= x_d;
    end
  end

endmodule

// ===== rtl/core/ilmc_lattice.sv =====
// Spin lattice memory with a clearing sweep after reset.
module ilmc_lattice #(
  parameter int Sites = 16384,
  parameter int AddrW = 14
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic             rd_data_o,
  input  logic             we_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic             wr_data_i,
  output logic             busy_o
);

  logic             mem [Sites];
  logic             busy_q;
  logic [AddrW-1:0] clr_q;

  assign busy_o = busy_q;

  // sweep every entry to zero once after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else if (busy_q) begin
      if (clr_q == AddrW'(Sites - 1)) begin
        busy_q <= 1'b0;
      end
      clr_q <= clr_q + 1'b1;
    end
  end

  // write port
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= 1'b0;
    end else if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

// ===== rtl/core/ilmc_stack.sv =====
// Walk stack memory for cluster growth.
module ilmc_stack #(
  parameter int Depth = 16384,
  parameter int AddrW = 14,
  parameter int DataW = 17
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem [Depth];

  // one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

// ===== rtl/core/ising_lattice_monte_carlo_unit.sv =====
// Ising lattice Monte Carlo unit: top level with controller and registers.
// The unit holds a SIDE_ROWS x SIDE_COLS lattice of one-bit spins with open
// edges in a single memory (one write, one read a cycle, registered read
// data) plus an up-spin count. After reset it sweeps the lattice to zero and
// takes no item meanwhile; configuration writes are taken at any time. Items
// run one at a time; a Wolff move checks the neighbours of each flipped site
// and pops it off the walk stack, but for the start site, which is never
// popped. A finished result waits in the output register while the next
// item is taken; while that register is still held by a stalled result, the
// item stays in its done state until the stall ends.
`include "ising_lattice_monte_carlo_unit_macros.svh"
module ising_lattice_monte_carlo_unit
  import ilmc_pkg::*;
#(
  parameter int SIDE_ROWS = 128,
  parameter int SIDE_COLS = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [6:0]         site_row_i,
  input  logic [6:0]         site_col_i,
  input  logic               spin_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               spin_out_o,
  output logic [CountW-1:0]  up_total_o,
  output logic [CountW-1:0]  flipped_sites_o
);

  localparam int Sites = SIDE_ROWS * SIDE_COLS;
  localparam int AW    = $clog2(Sites);
  localparam int SpW   = $clog2(Sites + 1);
  localparam int RW    = $clog2(SIDE_ROWS);
  localparam int CW    = $clog2(SIDE_COLS);
  localparam int StW   = RW + CW + 3;

  state_e state_q, state_d;

  // configuration
  logic           mode_q;
  logic [ThW-1:0] bond_q, alow_q, ahigh_q;

  // item and walk registers
  logic [1:0]     op_q;
  logic           val_q;
  logic [AW-1:0]  site_addr_q;
  logic [RW-1:0]  top_row_q, nb_row_q, nb_row;
  logic [CW-1:0]  top_col_q, nb_col_q, nb_col;
  logic [2:0]     top_dir_q;
  logic [AW-1:0]  nb_addr_q, nb_addr, in_addr;
  logic [SpW-1:0] sp_q;
  logic           clus_spin_q, self_spin_q, nbv_q, nb_ok;
  logic signed [3:0] e_q;
  logic [16:0]    limit_q, limit_d, p2;
  logic [32:0]    prod;
  logic [CountW-1:0] up_q, flipped_q;
  logic           spin_res_q;

  // output register
  logic              out_valid_q, out_spin_q;
  logic [CountW-1:0] out_up_q, out_flip_q;

  // memories and generator
  logic           lat_rd, lat_we, lat_wd, lat_busy;
  logic [AW-1:0]  lat_ra, lat_wa;
  logic           st_we;
  logic [AW-1:0]  st_wa, st_ra;
  logic [StW-1:0] st_rd;
  rng_ctrl_t      rng_ctrl;
  logic [ThW-1:0] draw;

  logic in_acc, in_inside, out_free, join_nb, m_acc, tog_en, tog_up;
  logic [RW-1:0] in_row;
  logic [CW-1:0] in_col;

  assign in_stall_o = (state_q != S_IDLE) || lat_busy;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_inside  = (int'(site_row_i) < SIDE_ROWS) && (int'(site_col_i) < SIDE_COLS);
  assign in_row     = RW'(site_row_i);
  assign in_col     = CW'(site_col_i);
  assign in_addr    = AW'(int'(in_row) * SIDE_COLS + int'(in_col));

  assign out_valid_o     = out_valid_q;
  assign spin_out_o      = out_spin_q;
  assign up_total_o      = out_up_q;
  assign flipped_sites_o = out_flip_q;

  // neighbour of the top site in its current direction
  always_comb begin
    nb_row = top_row_q;
    nb_col = top_col_q;
    nb_ok  = 1'b0;
    case (top_dir_q)
      DIR_UP: begin
        nb_ok  = top_row_q != '0;
        nb_row = top_row_q - 1'b1;
      end
      DIR_DOWN: begin
        nb_ok  = (int'(top_row_q) + 1) < SIDE_ROWS;
        nb_row = top_row_q + 1'b1;
      end
      DIR_LEFT: begin
        nb_ok  = top_col_q != '0;
        nb_col = top_col_q - 1'b1;
      end
      DIR_RIGHT: begin
        nb_ok  = (int'(top_col_q) + 1) < SIDE_COLS;
        nb_col = top_col_q + 1'b1;
      end
      default: nb_ok = 1'b0;
    endcase
  end
  assign nb_addr = AW'(int'(nb_row) * SIDE_COLS + int'(nb_col));

  // Metropolis acceptance limit from the energy change
  assign p2   = 17'h10000 - {1'b0, bond_q};
  assign prod = 33'(alow_q) * 33'(p2);
  always_comb begin
    case (e_q)
      4'sd1:   limit_d = p2;
      4'sd2:   limit_d = {1'b0, alow_q};
      4'sd3:   limit_d = prod[32:16];
      default: limit_d = {1'b0, ahigh_q};
    endcase
  end

  assign join_nb = (state_q == S_W_CHK) && (lat_rd != clus_spin_q) && (draw < bond_q);
  assign m_acc   = (e_q <= 4'sd0) || ({1'b0, draw} < limit_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = in_inside ? S_SITE : S_DONE;
      S_SITE: begin
        if (op_q == OP_MOVE) state_d = mode_q ? S_W_NB : S_M_RD;
        else state_d = S_DONE;
      end
      S_W_NB: begin
        if (top_dir_q == DIR_DONE) state_d = (sp_q == SpW'(1)) ? S_DONE : S_W_POP;
        else if (nb_ok) state_d = S_W_CHK;
      end
      S_W_POP: state_d = S_W_NB;
      S_W_CHK: state_d = S_W_NB;
      S_M_RD:  state_d = S_M_ACC;
      S_M_ACC: state_d = (top_dir_q == DIR_RIGHT) ? S_M_LIM : S_M_RD;
      S_M_LIM: state_d = S_M_DEC;
      S_M_DEC: state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // memory, generator and counter controls
  always_comb begin
    lat_ra   = (state_q == S_IDLE) ? in_addr : nb_addr;
    lat_we   = 1'b0;
    lat_wa   = site_addr_q;
    lat_wd   = 1'b0;
    st_we    = 1'b0;
    st_wa    = AW'(sp_q - 1'b1);
    st_ra    = AW'(sp_q - 2'd2);
    tog_en   = 1'b0;
    tog_up   = 1'b0;
    rng_ctrl.step = 1'b0;
    rng_ctrl.load = cfg_we_i && (cfg_index_i == CFG_SEED);
    rng_ctrl.seed = cfg_wdata_i;
    case (state_q)
      S_SITE: begin
        if (op_q == OP_WRITE) begin
          lat_we = lat_rd != val_q;
          lat_wd = val_q;
          tog_en = lat_rd != val_q;
          tog_up = val_q;
        end else if (op_q == OP_MOVE && mode_q) begin
          lat_we = 1'b1;
          lat_wd = !lat_rd;
          tog_en = 1'b1;
          tog_up = !lat_rd;
        end
      end
      S_W_CHK: begin
        rng_ctrl.step = lat_rd != clus_spin_q;
        lat_we = join_nb;
        lat_wa = nb_addr_q;
        lat_wd = clus_spin_q;
        tog_en = join_nb;
        tog_up = clus_spin_q;
        st_we  = join_nb && (sp_q < SpW'(Sites));
      end
      S_M_DEC: begin
        rng_ctrl.step = e_q > 4'sd0;
        lat_we = m_acc;
        lat_wd = !self_spin_q;
        tog_en = m_acc;
        tog_up = !self_spin_q;
      end
      default: lat_we = 1'b0;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      up_q        <= '0;
      sp_q        <= '0;
      mode_q      <= 1'b1;
      bond_q      <= 16'd37054;
      alow_q      <= 16'd12379;
      ahigh_q     <= 16'd2338;
    end else begin
      state_q <= state_d;
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MODE:  mode_q  <= cfg_wdata_i[0];
          CFG_BOND:  bond_q  <= cfg_wdata_i[ThW-1:0];
          CFG_ALOW:  alow_q  <= cfg_wdata_i[ThW-1:0];
          CFG_AHIGH: ahigh_q <= cfg_wdata_i[ThW-1:0];
          default:   mode_q  <= mode_q;
        endcase
      end
      // up-spin count
      if (tog_en) up_q <= tog_up ? up_q + 1'b1 : up_q - 1'b1;
      // stack depth
      if (state_q == S_SITE && op_q == OP_MOVE && mode_q) sp_q <= SpW'(1);
      else if (state_q == S_W_NB && top_dir_q == DIR_DONE && sp_q != SpW'(1))
        sp_q <= sp_q - 1'b1;
      else if (st_we) sp_q <= sp_q + 1'b1;
      // result transfer
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_q        <= op_i;
          val_q       <= spin_value_i;
          site_addr_q <= in_addr;
          top_row_q   <= in_row;
          top_col_q   <= in_col;
          top_dir_q   <= DIR_UP;
          flipped_q   <= '0;
          spin_res_q  <= 1'b0;
          e_q         <= 4'sd0;
        end
      end
      S_SITE: begin
        self_spin_q <= lat_rd;
        if (op_q == OP_WRITE) begin
          spin_res_q <= val_q;
        end else if (op_q == OP_MOVE && mode_q) begin
          clus_spin_q <= !lat_rd;
          spin_res_q  <= !lat_rd;
          flipped_q   <= CountW'(1);
        end else begin
          spin_res_q <= lat_rd;
        end
      end
      S_W_NB: begin
        if (top_dir_q != DIR_DONE) begin
          top_dir_q <= top_dir_q + 1'b1;
          nb_row_q  <= nb_row;
          nb_col_q  <= nb_col;
          nb_addr_q <= nb_addr;
        end
      end
      S_W_POP: {top_row_q, top_col_q, top_dir_q} <= st_rd;
      S_W_CHK: begin
        if (join_nb) begin
          flipped_q <= flipped_q + 1'b1;
          if (st_we) begin
            top_row_q <= nb_row_q;
            top_col_q <= nb_col_q;
            top_dir_q <= DIR_UP;
          end
        end
      end
      S_M_RD:  nbv_q <= nb_ok;
      S_M_ACC: begin
        if (nbv_q) e_q <= (lat_rd == self_spin_q) ? e_q + 4'sd1 : e_q - 4'sd1;
        top_dir_q <= top_dir_q + 1'b1;
      end
      S_M_LIM: limit_q <= limit_d;
      S_M_DEC: begin
        if (m_acc) begin
          flipped_q  <= CountW'(1);
          spin_res_q <= !self_spin_q;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_spin_q <= spin_res_q;
          out_up_q   <= up_q;
          out_flip_q <= flipped_q;
        end
      end
      default: nbv_q <= nbv_q;
    endcase
  end

  ilmc_lattice #(
    .Sites (Sites),
    .AddrW (AW)
  ) u_lattice (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (lat_ra),
    .rd_data_o (lat_rd),
    .we_i      (lat_we),
    .wr_addr_i (lat_wa),
    .wr_data_i (lat_wd),
    .busy_o    (lat_busy)
  );

  ilmc_stack #(
    .Depth (Sites),
    .AddrW (AW),
    .DataW (StW)
  ) u_stack (
    .clk_i     (clk_i),
    .we_i      (st_we),
    .wr_addr_i (st_wa),
    .wr_data_i ({top_row_q, top_col_q, top_dir_q}),
    .rd_addr_i (st_ra),
    .rd_data_o (st_rd)
  );

  ilmc_rng u_rng (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (rng_ctrl),
    .draw_o (draw)
  );

  `ILMC_ASSERT(a_sp_bound, sp_q <= SpW'(Sites))
  `ILMC_ASSERT(a_walk_nonempty, (state_q == S_W_NB || state_q == S_W_CHK) |-> sp_q != '0)
  `ILMC_ASSERT(a_metro_single, (state_q == S_DONE && !mode_q) |-> flipped_q <= CountW'(1))
  `ILMC_ASSERT_NEVER(a_no_item_in_clear, lat_busy && state_q != S_IDLE)

endmodule

// ===== tb/sv/ilmc_checker.sv =====
// Checker for the Ising lattice unit: lattice predictor and result compare.
`timescale 1ns / 100ps
module ilmc_checker
  import ilmc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [1:0]        op_i,
  input  logic [6:0]        site_row_i,
  input  logic [6:0]        site_col_i,
  input  logic              spin_value_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic              spin_out_i,
  input  logic [CountW-1:0] up_total_i,
  input  logic [CountW-1:0] flipped_sites_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam int Rows  = 128;
  localparam int Cols  = 128;
  localparam int Sites = Rows * Cols;

  typedef struct packed {
    logic              spin;
    logic [CountW-1:0] up_total;
    logic [CountW-1:0] flipped;
  } site_result_t;

  // predicted lattice and its registers
  bit          lattice_bits[Sites];
  int unsigned up_spins;
  bit [31:0]   gen_word;
  bit          wolff_mode;
  bit [15:0]   bond_th, acc_low_th, acc_high_th;
  int          walk_site[Sites];
  int          walk_dir[Sites];

  site_result_t result_q[$];
  int           fails;

  assign fail_count_o = fails;
  assign pending_o    = result_q.size();

  // advance the xorshift generator and return its upper half
  function automatic bit [15:0] next_draw();
    gen_word ^= gen_word << 13;
    gen_word ^= gen_word >> 17;
    gen_word ^= gen_word << 5;
    return gen_word[31:16];
  endfunction

  function automatic void flip_spin(int idx);
    lattice_bits[idx] ^= 1'b1;
    if (lattice_bits[idx]) up_spins++;
    else up_spins--;
  endfunction

  // neighbour in direction dir, zero when it falls off the open edge
  function automatic bit neighbour_of(int idx, int dir, output int nb);
    int r, c;
    r = idx / Cols;
    c = idx % Cols;
    nb = 0;
    case (dir)
      DIR_UP: begin
        if (r == 0) return 1'b0;
        r--;
      end
      DIR_DOWN: begin
        if (r + 1 >= Rows) return 1'b0;
        r++;
      end
      DIR_LEFT: begin
        if (c == 0) return 1'b0;
        c--;
      end
      default: begin
        if (c + 1 >= Cols) return 1'b0;
        c++;
      end
    endcase
    nb = r * Cols + c;
    return 1'b1;
  endfunction

  // depth-first cluster growth; returns the number of flipped sites
  function automatic int grow_cluster(int start);
    int depth, top, cur, dir, nb, flipped;
    flipped = 1;
    flip_spin(start);
    walk_site[0] = start;
    walk_dir[0]  = 0;
    depth = 1;
    while (depth > 0) begin
      top = depth - 1;
      cur = walk_site[top];
      dir = walk_dir[top];
      if (dir >= DIR_DONE) begin
        depth--;
        continue;
      end
      walk_dir[top] = dir + 1;
      if (!neighbour_of(cur, dir, nb)) continue;
      if (lattice_bits[nb] == lattice_bits[cur]) continue;
      if (next_draw() >= bond_th) continue;
      flip_spin(nb);
      flipped++;
      if (depth < Sites) begin
        walk_site[depth] = nb;
        walk_dir[depth]  = 0;
        depth++;
      end
    end
    return flipped;
  endfunction

  // single-site flip with energy-based acceptance
  function automatic int try_single_flip(int idx);
    int           energy, nb;
    longint unsigned p2, lim;
    energy = 0;
    for (int d = 0; d < 4; d++) begin
      if (!neighbour_of(idx, d, nb)) continue;
      if (lattice_bits[nb] == lattice_bits[idx]) energy++;
      else energy--;
    end
    if (energy > 0) begin
      p2 = 65536 - bond_th;
      if (energy == 1) lim = p2;
      else if (energy == 2) lim = acc_low_th;
      else if (energy == 3) lim = (acc_low_th * p2) >> 16;
      else lim = acc_high_th;
      if (next_draw() >= lim) return 0;
    end
    flip_spin(idx);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int           idx, flipped;
    site_result_t want;
    if (!rst_ni) begin
      foreach (lattice_bits[i]) lattice_bits[i] = 1'b0;
      up_spins    = 0;
      gen_word    = SEED_DEFAULT;
      wolff_mode  = 1'b1;
      bond_th     = 16'd37054;
      acc_low_th  = 16'd12379;
      acc_high_th = 16'd2338;
      result_q.delete();
      fails = 0;
    end else begin
      // track register writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MODE:  wolff_mode  = cfg_wdata_i[0];
          CFG_BOND:  bond_th     = cfg_wdata_i[15:0];
          CFG_ALOW:  acc_low_th  = cfg_wdata_i[15:0];
          CFG_AHIGH: acc_high_th = cfg_wdata_i[15:0];
          CFG_SEED:  gen_word    = (cfg_wdata_i == 0) ? SEED_DEFAULT : cfg_wdata_i;
          default: ;
        endcase
      end
      // predict on each input transfer
      if (in_valid_i && !in_stall_i) begin
        idx = site_row_i * Cols + site_col_i;
        flipped = 0;
        if (op_i == OP_MOVE) begin
          flipped = wolff_mode ? grow_cluster(idx) : try_single_flip(idx);
        end else if (op_i == OP_WRITE) begin
          if (lattice_bits[idx] != spin_value_i) flip_spin(idx);
        end
        want.spin     = lattice_bits[idx];
        want.up_total = up_spins[CountW-1:0];
        want.flipped  = flipped[CountW-1:0];
        result_q.push_back(want);
      end
      // compare each output transfer with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result: spin %0d up %0d flipped %0d",
                                    spin_out_i, up_total_i, flipped_sites_i);
        end else begin
          want = result_q.pop_front();
          if (want.spin !== spin_out_i || want.up_total !== up_total_i ||
              want.flipped !== flipped_sites_i) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: spin %0d/%0d up %0d/%0d flipped %0d/%0d (exp/act)",
                       want.spin, spin_out_i, want.up_total, up_total_i,
                       want.flipped, flipped_sites_i);
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the Ising lattice unit testbench: clock, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
  import ilmc_pkg::*;

  localparam int WatchLimit = 600000;
  localparam int PhaseItems = 325;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0]    cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         op_i = OP_READ;
  logic [6:0]         site_row_i = '0;
  logic [6:0]         site_col_i = '0;
  logic               spin_value_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               spin_out_o;
  logic [CountW-1:0]  up_total_o;
  logic [CountW-1:0]  flipped_sites_o;
  int                 fail_count, pending;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  ising_lattice_monte_carlo_unit u_top (.*);

  ilmc_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .op_i, .site_row_i, .site_col_i,
    .spin_value_i, .out_valid_i(out_valid_o), .out_stall_i,
    .spin_out_i(spin_out_o), .up_total_i(up_total_o),
    .flipped_sites_i(flipped_sites_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // random receiver stall
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  // end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  // present one item and hold it until the transfer
  task automatic send_item(logic [1:0] op, int row, int col, logic val);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    site_row_i   <= row[6:0];
    site_col_i   <= col[6:0];
    spin_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drop valid and wait until every result has come back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] index, logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly a corner window so structure builds up; edges and anywhere too
  function automatic int pick_coord();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) return $urandom_range(11);
    if (sel < 7) return (sel == 5) ? 0 : 127;
    return $urandom_range(127);
  endfunction

  task automatic random_items(int count);
    int sel;
    logic [1:0] op;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 50) op = OP_MOVE;
      else if (sel < 80) op = OP_WRITE;
      else if (sel < 95) op = OP_READ;
      else op = 2'd3;
      send_item(op, pick_coord(), pick_coord(), $urandom_range(1));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reads and writes at the corners, an unused opcode
    send_item(OP_WRITE, 0, 0, 1'b1);
    send_item(OP_READ, 0, 0, 1'b0);
    send_item(OP_WRITE, 127, 127, 1'b1);
    send_item(OP_WRITE, 127, 127, 1'b1);
    send_item(OP_READ, 127, 0, 1'b0);
    send_item(2'd3, 0, 127, 1'b0);
    send_item(OP_WRITE, 127, 127, 1'b0);
    send_item(OP_WRITE, 0, 0, 1'b0);
    drain();

    // directed single-site moves: corner, edge, bulk and a mixed edge
    write_reg(CFG_MODE, 32'd0);
    write_reg(CFG_BOND, 32'd0);
    write_reg(CFG_ALOW, 32'hFFFF);
    write_reg(CFG_AHIGH, 32'hFFFF);
    write_reg(CFG_SEED, 32'd0);
    send_item(OP_MOVE, 0, 0, 1'b0);
    send_item(OP_MOVE, 0, 5, 1'b0);
    send_item(OP_MOVE, 5, 5, 1'b0);
    send_item(OP_MOVE, 0, 4, 1'b0);
    send_item(OP_MOVE, 0, 4, 1'b0);
    send_item(OP_MOVE, 127, 64, 1'b0);
    drain();
    write_reg(CFG_AHIGH, 32'd0);
    write_reg(CFG_ALOW, 32'd0);
    send_item(OP_MOVE, 9, 9, 1'b0);
    send_item(OP_MOVE, 0, 9, 1'b0);
    drain();

    // directed cluster moves: bond never, then nearly always
    write_reg(CFG_MODE, 32'd1);
    write_reg(CFG_SEED, 32'hFFFFFFFF);
    send_item(OP_MOVE, 64, 64, 1'b0);
    drain();
    write_reg(CFG_BOND, 32'hFFFF);
    send_item(OP_MOVE, 64, 64, 1'b0);
    send_item(OP_READ, 127, 127, 1'b0);
    drain();

    // random phases alternating the move kind; idling per the phase pair
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct  = 38;
          recv_stall_pct = 88;
        end
        1: begin
          send_idle_pct  = 88;
          recv_stall_pct = 38;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      write_reg(CFG_MODE, ph % 2);
      write_reg(CFG_BOND, (ph % 2) ? $urandom_range(30000) : $urandom_range(65535));
      write_reg(CFG_ALOW, $urandom_range(65535));
      write_reg(CFG_AHIGH, $urandom_range(65535));
      write_reg(CFG_SEED, $urandom);
      random_items(PhaseItems / 2);
      if (ph == 2) drain();
      random_items(PhaseItems - PhaseItems / 2);
      drain();
    end

    if (fail_count == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
